// ===== rtl/http_request_framer_macros.svh =====
// assertion macros shared by the framer modules
// no dependencies; every use expects clk and rst_n in scope
`ifndef HTTP_REQUEST_FRAMER_MACROS_SVH
`define HTTP_REQUEST_FRAMER_MACROS_SVH

// same-cycle implication
`define HRF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// next-cycle implication
`define HRF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

// ===== rtl/hrf_pkg.sv =====
// types, codes and constants of the http request framer
// no dependencies
package hrf_pkg;

    localparam int LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [15:0] DEFAULT_CAPACITY = 16'd4096;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [4:0] KEY_LEN = 5'd15;
    localparam logic [4:0] LINE_POS_MAX = 5'd16;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5a;

    typedef enum logic [5:0] {
        PH_METHOD  = 6'b000001,
        PH_PATH    = 6'b000010,
        PH_VERSION = 6'b000100,
        PH_HEADERS = 6'b001000,
        PH_BODY    = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_METHOD   = 3'd1;
    localparam logic [2:0] EV_PATH     = 3'd2;
    localparam logic [2:0] EV_VERSION  = 3'd3;
    localparam logic [2:0] EV_HDR_LINE = 3'd4;
    localparam logic [2:0] EV_HDR_END  = 3'd5;
    localparam logic [2:0] EV_DONE     = 3'd6;
    localparam logic [2:0] EV_ERROR    = 3'd7;

    localparam logic [1:0] NP_SKIP = 2'd0;
    localparam logic [1:0] NP_NUM  = 2'd1;
    localparam logic [1:0] NP_BAD  = 2'd2;

    typedef struct packed {
        logic [7:0] data_in;
        logic       conn_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_out;
        logic        keep;
        logic [2:0]  event_res;
        logic [15:0] offset;
        logic [15:0] body_length;
        logic        last;
    } out_item_t;

    // header line scanner state
    typedef struct packed {
        logic [4:0]             pos;
        logic                   pm;
        logic [1:0]             np;
        logic [LENGTH_BITS-1:0] nv;
    } line_t;

    localparam line_t LINE_RST = '{pos: 5'd0, pm: 1'b1, np: NP_SKIP, nv: '0};

    // results of one byte handed from the parser to the result queue
    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  r0;
        out_item_t  r1;
    } push_t;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hrf_front.sv =====
// byte parser: phase tracking, content-length scan, result generation
// depends on hrf_pkg and http_request_framer_macros.svh
`include "http_request_framer_macros.svh"
module hrf_front
    import hrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    in_item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output push_t       wr
);

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] sl_reg, sl_next;
    logic                   pcr_reg, pcr_next;
    line_t                  line_reg, line_next;
    logic                   lv_reg, lv_next;
    logic [LENGTH_BITS-1:0] cl_reg, cl_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [15:0]            cap_reg;
    push_t                  res;

    function automatic out_item_t mk(input logic [7:0] d, input logic k, input logic [2:0] ev,
                                     input logic [LENGTH_BITS-1:0] off,
                                     input logic [LENGTH_BITS-1:0] bl);
        out_item_t o;
        o.data_out    = d;
        o.keep        = k;
        o.event_res   = ev;
        o.offset      = 16'(off);
        o.body_length = 16'(bl);
        o.last        = 1'b0;
        return o;
    endfunction

    function automatic line_t feed(input line_t l, input logic [7:0] b);
        line_t                  r;
        logic [7:0]             lc;
        logic                   dig;
        logic                   ws;
        logic [3:0]             d;
        logic [LENGTH_BITS+3:0] prod;
        r    = l;
        lc   = (b >= CH_UA && b <= CH_UZ) ? b + 8'd32 : b;
        dig  = (b >= CH_0 && b <= CH_9);
        ws   = (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
        d    = 4'(b - CH_0);
        prod = (LENGTH_BITS+4)'(l.nv) * (LENGTH_BITS+4)'(10) + (LENGTH_BITS+4)'(d);
        if (l.pos < KEY_LEN)
        begin
            if (lc != key_char(l.pos[3:0]))
                r.pm = 1'b0;
        end
        else if (l.pm)
        begin
            case (l.np)
                NP_SKIP:
                begin
                    if (dig)
                    begin
                        r.np = NP_NUM;
                        r.nv = LENGTH_BITS'(d);
                    end
                    else if (!ws)
                        r.np = NP_BAD;
                end
                NP_NUM:
                begin
                    if (dig)
                        r.nv = (prod > (LENGTH_BITS+4)'(LEN_MAX)) ? LEN_MAX
                                                                  : prod[LENGTH_BITS-1:0];
                    else
                        r.np = NP_BAD;
                end
                default: ;
            endcase
        end
        if (l.pos < LINE_POS_MAX)
            r.pos = l.pos + 5'd1;
        return r;
    endfunction

    always_comb
    begin
        phase_t                 ph;
        logic [LENGTH_BITS-1:0] sl, sl1, sl2;
        logic                   pcr, lv, ok0, ok1, done;
        line_t                  ln, ln_a;
        logic [LENGTH_BITS-1:0] cl, rem;
        logic [7:0]             b;

        b   = in_item.data_in;
        // a connection start restarts the request before this byte
        ph  = in_item.conn_start ? PH_METHOD : phase_reg;
        sl  = in_item.conn_start ? '0 : sl_reg;
        pcr = in_item.conn_start ? 1'b0 : pcr_reg;
        ln  = in_item.conn_start ? LINE_RST : line_reg;
        lv  = in_item.conn_start ? 1'b0 : lv_reg;
        cl  = in_item.conn_start ? '0 : cl_reg;
        rem = in_item.conn_start ? '0 : rem_reg;

        phase_next = ph;
        sl_next    = sl;
        pcr_next   = pcr;
        line_next  = ln;
        lv_next    = lv;
        cl_next    = cl;
        rem_next   = rem;
        res        = '0;
        ln_a       = ln;
        done       = 1'b0;

        sl1 = sl + 1'b1;
        sl2 = sl1 + 1'b1;
        ok0 = (32'(sl) < 32'(cap_reg)) && (sl != LEN_MAX);
        ok1 = (32'(sl1) < 32'(cap_reg)) && (sl1 != LEN_MAX);

        unique case (ph)
            PH_METHOD, PH_PATH:
            begin
                res.cnt = 2'd1;
                if (!ok0)
                begin
                    res.r0     = mk(8'h00, 1'b0, EV_ERROR, sl, '0);
                    phase_next = PH_ERROR;
                end
                else if (b == CH_SP)
                begin
                    res.r0     = mk(8'h00, 1'b1, (ph == PH_METHOD) ? EV_METHOD : EV_PATH,
                                    sl1, '0);
                    sl_next    = sl1;
                    phase_next = (ph == PH_METHOD) ? PH_PATH : PH_VERSION;
                end
                else
                begin
                    res.r0  = mk(b, 1'b1, EV_NONE, sl1, '0);
                    sl_next = sl1;
                end
            end
            PH_VERSION, PH_HEADERS:
            begin
                if (pcr && b == CH_LF)
                begin
                    pcr_next = 1'b0;
                    if (ph == PH_HEADERS && ln.pos == 5'd0)
                    begin
                        // blank line ends the headers
                        res.cnt = 2'd1;
                        res.r0  = mk(8'h00, 1'b0, EV_HDR_END, sl, '0);
                        if (lv && cl != '0)
                        begin
                            phase_next = PH_BODY;
                            rem_next   = cl;
                        end
                        else
                        begin
                            res.cnt    = 2'd2;
                            res.r1     = mk(8'h00, 1'b0, EV_DONE, sl, '0);
                            phase_next = PH_METHOD;
                            sl_next    = '0;
                            line_next  = LINE_RST;
                            lv_next    = 1'b0;
                            cl_next    = '0;
                            rem_next   = '0;
                        end
                    end
                    else if (!ok0)
                    begin
                        res.cnt    = 2'd1;
                        res.r0     = mk(8'h00, 1'b0, EV_ERROR, sl, '0);
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        res.cnt = 2'd2;
                        res.r0  = mk(8'h00, 1'b1, EV_NONE, sl1, '0);
                        sl_next = sl1;
                        if (!ok1)
                        begin
                            res.r1     = mk(8'h00, 1'b0, EV_ERROR, sl1, '0);
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            res.r1  = mk(8'h00, 1'b1,
                                         (ph == PH_VERSION) ? EV_VERSION : EV_HDR_LINE,
                                         sl2, '0);
                            sl_next = sl2;
                            if (ph == PH_VERSION)
                                phase_next = PH_HEADERS;
                            else if (ln.pm && ln.pos >= LINE_POS_MAX)
                            begin
                                lv_next = (ln.np == NP_NUM);
                                cl_next = (ln.np == NP_NUM) ? ln.nv : '0;
                            end
                            line_next = LINE_RST;
                        end
                    end
                end
                else if (pcr)
                begin
                    // held cr turns out to be an ordinary byte
                    pcr_next = 1'b0;
                    res.cnt  = 2'd1;
                    if (!ok0)
                    begin
                        res.r0     = mk(8'h00, 1'b0, EV_ERROR, sl, '0);
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        res.r0    = mk(CH_CR, 1'b1, EV_NONE, sl1, '0);
                        sl_next   = sl1;
                        ln_a      = (ph == PH_HEADERS) ? feed(ln, CH_CR) : ln;
                        line_next = ln_a;
                        if (b == CH_CR)
                            pcr_next = 1'b1;
                        else if (!ok1)
                        begin
                            res.cnt    = 2'd2;
                            res.r1     = mk(8'h00, 1'b0, EV_ERROR, sl1, '0);
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            res.cnt = 2'd2;
                            res.r1  = mk(b, 1'b1, EV_NONE, sl2, '0);
                            sl_next = sl2;
                            if (ph == PH_HEADERS)
                                line_next = feed(ln_a, b);
                        end
                    end
                end
                else if (b == CH_CR)
                    pcr_next = 1'b1;
                else
                begin
                    res.cnt = 2'd1;
                    if (!ok0)
                    begin
                        res.r0     = mk(8'h00, 1'b0, EV_ERROR, sl, '0);
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        res.r0  = mk(b, 1'b1, EV_NONE, sl1, '0);
                        sl_next = sl1;
                        if (ph == PH_HEADERS)
                            line_next = feed(ln, b);
                    end
                end
            end
            PH_BODY:
            begin
                done    = (rem <= LENGTH_BITS'(1));
                res.cnt = 2'd1;
                if (!ok0)
                begin
                    res.r0     = mk(8'h00, 1'b0, EV_ERROR, sl, '0);
                    phase_next = PH_ERROR;
                end
                else if (done)
                begin
                    res.r0     = mk(b, 1'b1, EV_DONE, sl1, cl);
                    phase_next = PH_METHOD;
                    sl_next    = '0;
                    line_next  = LINE_RST;
                    lv_next    = 1'b0;
                    cl_next    = '0;
                    rem_next   = '0;
                end
                else
                begin
                    res.r0   = mk(b, 1'b1, EV_NONE, sl1, '0);
                    sl_next  = sl1;
                    rem_next = rem - 1'b1;
                end
            end
            PH_ERROR: ;
            default: ;
        endcase

        if (res.cnt == 2'd2)
            res.r1.last = 1'b1;
        else if (res.cnt == 2'd1)
            res.r0.last = 1'b1;
    end

    always_comb
    begin
        wr = res;
        if (!accept)
            wr.cnt = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            sl_reg    <= '0;
            pcr_reg   <= 1'b0;
            line_reg  <= LINE_RST;
            lv_reg    <= 1'b0;
            cl_reg    <= '0;
            rem_reg   <= '0;
            cap_reg   <= DEFAULT_CAPACITY;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (accept)
            begin
                phase_reg <= phase_next;
                sl_reg    <= sl_next;
                pcr_reg   <= pcr_next;
                line_reg  <= line_next;
                lv_reg    <= lv_next;
                cl_reg    <= cl_next;
                rem_reg   <= rem_next;
            end
        end
    end

    `HRF_ASSERT_NOW(a_err_quiet, accept && phase_reg == PH_ERROR && !in_item.conn_start, wr.cnt == 2'd0)
    `HRF_ASSERT_NOW(a_keep_off, wr.cnt != 2'd0 && wr.r0.keep, wr.r0.offset != 16'd0)
    `HRF_ASSERT_NEXT(a_idle_hold, !accept && !cfg_we, $stable(sl_reg) && $stable(phase_reg))

endmodule

// ===== rtl/hrf_queue.sv =====
// result queue: takes up to two results a cycle, hands out one
// depends on hrf_pkg and http_request_framer_macros.svh
`include "http_request_framer_macros.svh"
module hrf_queue
    import hrf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     wr,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    // DEPTH is a power of two, at least 2
    localparam int AW = $clog2(DEPTH);

    out_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            pop_ok;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg > (AW+1)'(DEPTH - 2));
    assign pop_ok   = pop && !empty;
    assign out_item = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr.cnt != 2'd0)
            mem_reg[wp_reg] <= wr.r0;
        if (wr.cnt == 2'd2)
            mem_reg[wp_reg + 1'b1] <= wr.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + AW'(wr.cnt);
            if (pop_ok)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr.cnt) - (AW+1)'(pop_ok);
        end
    end

    `HRF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= (AW+1)'(DEPTH))
    `HRF_ASSERT_NEXT(a_pop_dec, pop_ok && wr.cnt == 2'd0, cnt_reg == $past(cnt_reg) - 1'b1)
    `HRF_ASSERT_NEXT(a_push_inc, !pop_ok && wr.cnt == 2'd2, cnt_reg == $past(cnt_reg) + 2'd2)

endmodule

// ===== rtl/http_request_framer.sv =====
// top level of the http request framer
// depends on hrf_pkg, hrf_front and hrf_queue
//
//  channel   direction  handshake            payload
//  input     in         push / full          in_item  (in_item_t)
//  result    out        pop / empty          out_item (out_item_t)
//  config    in         cfg_we               cfg_data (buffer capacity)
//
// one byte is accepted per cycle while full is low; the parser updates its state
// in the same cycle and writes zero, one or two results into the result queue
// results leave at one per cycle while pop is high, so the queue output port sets
// the long-run rate when bytes cause two results; full rises while fewer than two slots are free
// reset clears parser state and the queue and sets the capacity to 4096
module http_request_framer
    import hrf_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    in_item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    push_t wr;
    logic  accept;

    assign accept = push && !full;

    hrf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_item  (in_item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .wr       (wr)
    );

    hrf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule
